>>> rtl/rbpt_pkg.sv
package rbpt_pkg;

  // item kinds on the input tuser
  typedef enum logic [1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_START = 2'd1,
    FUNC_STOP  = 2'd2,
    FUNC_NONE  = 2'd3
  } func_e;

  // register map, index i at byte address 4*i
  localparam int unsigned ADDR_W  = 5;
  localparam int unsigned CFG_W   = 32;
  localparam logic [2:0] REG_MAX_DUR   = 3'd0;
  localparam logic [2:0] REG_CD_WINDOW = 3'd1;
  localparam logic [2:0] REG_CD_ON     = 3'd2;
  localparam logic [2:0] REG_CD_START  = 3'd3;
  localparam logic [2:0] REG_CD_END    = 3'd4;
  localparam logic [2:0] REG_AL_ON     = 3'd5;
  localparam logic [2:0] REG_AL_START  = 3'd6;
  localparam logic [2:0] REG_AL_END    = 3'd7;

  // field widths
  localparam int unsigned LONG_W = 24;
  localparam int unsigned GAP_W  = 16;

  // reset values
  localparam logic [LONG_W-1:0] RST_MAX_DUR   = 24'd60000;
  localparam logic [LONG_W-1:0] RST_CD_WINDOW = 24'd30000;
  localparam logic [GAP_W-1:0]  RST_CD_ON     = 16'd300;
  localparam logic [GAP_W-1:0]  RST_CD_START  = 16'd2700;
  localparam logic [GAP_W-1:0]  RST_CD_END    = 16'd100;
  localparam logic [GAP_W-1:0]  RST_AL_ON     = 16'd80;
  localparam logic [GAP_W-1:0]  RST_AL_START  = 16'd1420;
  localparam logic [GAP_W-1:0]  RST_AL_END    = 16'd120;

  // fixed ramp window of the alarm pattern
  localparam logic [LONG_W-1:0] AL_WINDOW = 24'd12000;

endpackage

>>> rtl/ramped_beep_pattern_timer.sv
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid/s_axis_tready    tuser[1:0] func, tdata[0] pattern
// m_axis    out  m_axis_tvalid/m_axis_tready    tdata[0] buzzer_on, tdata[1] active
// apb       in   psel/penable/pwrite, pready=1  paddr 4*index, pwdata/prdata 32 bits
//
// start, stop and plain ticks go from accept through the eval and push steps to the output register.
// a tick that turns the buzzer off inside the ramp window adds multiply, divide and finish steps:
// the off gap comes from a bit-serial multiply and a restoring divide, one bit a cycle.
// one item is in work at a time; the next is accepted while a result waits in m_axis.
// rst_ni clears control state and loads the register reset values, no clearing pass.
module ramped_beep_pattern_timer
  import rbpt_pkg::*;
#(
  parameter int unsigned TIME_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [0] pattern
  input  logic [1:0]        s_axis_tuser,   // [1:0] func
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [7:0]        m_axis_tdata,   // [0] buzzer_on, [1] active
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [CFG_W-1:0]  pwdata,
  output logic [CFG_W-1:0]  prdata,
  output logic              pready
);

  localparam int unsigned TB  = TIME_BITS;
  localparam int unsigned WW  = (TIME_BITS > LONG_W) ? TIME_BITS : LONG_W;
  localparam int unsigned RW  = WW + 1;
  localparam int unsigned PW  = TIME_BITS + GAP_W;
  localparam int unsigned CNW = $clog2(GAP_W);
  localparam logic [CNW-1:0] CNT_LAST = CNW'(GAP_W - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_MUL,
    S_DIV,
    S_FIN,
    S_PUSH
  } state_e;

  // configuration registers
  logic [LONG_W-1:0] max_dur_q, cd_win_q;
  logic [GAP_W-1:0]  cd_on_q, cd_start_q, cd_end_q, al_on_q, al_start_q, al_end_q;

  // control and datapath
  state_e            state_q;
  func_e             func_q;
  logic              pattern_q;
  logic              running_q, alarm_q, level_q;
  logic [TB-1:0]     elapsed_q;
  logic [TB:0]       toggle_q;
  logic [TB-1:0]     mcand_q;
  logic [PW-1:0]     prod_q;
  logic [RW-1:0]     rem_q;
  logic [GAP_W-1:0]  quo_q;
  logic [CNW-1:0]    cnt_q;
  logic              m_valid_q;
  logic [1:0]        m_data_q;

  logic              cfg_wr;
  logic [TB-1:0]     elapsed_inc;
  logic [GAP_W-1:0]  sel_on, sel_start, sel_end, gap_diff, gap_val;
  logic [WW-1:0]     sel_win;
  logic              ge_max, ge_tog, ge_win, ramp_down;
  logic [TB:0]       mul_top;
  logic [PW-1:0]     prod_nx;
  logic [RW-1:0]     div_t, div_r;
  logic              div_ge;
  logic              push_ok;

  // apb port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dur_q  <= RST_MAX_DUR;
      cd_win_q   <= RST_CD_WINDOW;
      cd_on_q    <= RST_CD_ON;
      cd_start_q <= RST_CD_START;
      cd_end_q   <= RST_CD_END;
      al_on_q    <= RST_AL_ON;
      al_start_q <= RST_AL_START;
      al_end_q   <= RST_AL_END;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_MAX_DUR:   max_dur_q  <= pwdata[LONG_W-1:0];
        REG_CD_WINDOW: cd_win_q   <= pwdata[LONG_W-1:0];
        REG_CD_ON:     cd_on_q    <= pwdata[GAP_W-1:0];
        REG_CD_START:  cd_start_q <= pwdata[GAP_W-1:0];
        REG_CD_END:    cd_end_q   <= pwdata[GAP_W-1:0];
        REG_AL_ON:     al_on_q    <= pwdata[GAP_W-1:0];
        REG_AL_START:  al_start_q <= pwdata[GAP_W-1:0];
        REG_AL_END:    al_end_q   <= pwdata[GAP_W-1:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (paddr[4:2])
      REG_MAX_DUR:   prdata = CFG_W'(max_dur_q);
      REG_CD_WINDOW: prdata = CFG_W'(cd_win_q);
      REG_CD_ON:     prdata = CFG_W'(cd_on_q);
      REG_CD_START:  prdata = CFG_W'(cd_start_q);
      REG_CD_END:    prdata = CFG_W'(cd_end_q);
      REG_AL_ON:     prdata = CFG_W'(al_on_q);
      REG_AL_START:  prdata = CFG_W'(al_start_q);
      REG_AL_END:    prdata = CFG_W'(al_end_q);
      default:       prdata = '0;
    endcase
  end

  // pattern parameters of the running mode
  assign sel_on    = alarm_q ? al_on_q    : cd_on_q;
  assign sel_start = alarm_q ? al_start_q : cd_start_q;
  assign sel_end   = alarm_q ? al_end_q   : cd_end_q;
  assign sel_win   = alarm_q ? WW'(AL_WINDOW) : WW'(cd_win_q);
  assign ramp_down = (sel_start >= sel_end);
  assign gap_diff  = ramp_down ? (sel_start - sel_end) : (sel_end - sel_start);

  // tick evaluation, saturating elapsed time
  assign elapsed_inc = (elapsed_q == {TB{1'b1}}) ? elapsed_q : (elapsed_q + 1'b1);
  assign ge_max      = (WW'(elapsed_inc) >= WW'(max_dur_q));
  assign ge_tog      = ({1'b0, elapsed_inc} >= toggle_q);
  assign ge_win      = (WW'(elapsed_inc) >= sel_win);

  // one multiplier bit per cycle, product shifts down through prod_q
  assign mul_top = {1'b0, prod_q[PW-1:GAP_W]} + (prod_q[0] ? {1'b0, mcand_q} : '0);
  assign prod_nx = {mul_top, prod_q[GAP_W-1:1]};

  // one quotient bit per cycle, remainder stays below the window
  assign div_t  = {rem_q[RW-2:0], quo_q[GAP_W-1]};
  assign div_ge = (div_t >= RW'(sel_win));
  assign div_r  = div_ge ? (div_t - RW'(sel_win)) : div_t;

  // ceiling on the falling ramp, floor on the rising one
  assign gap_val = ramp_down ? (sel_start - quo_q - GAP_W'(rem_q != '0))
                             : (sel_start + quo_q);

  assign push_ok       = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {6'b0, m_data_q};

  // sequencer, pattern state and output word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      func_q    <= FUNC_TICK;
      pattern_q <= 1'b0;
      running_q <= 1'b0;
      alarm_q   <= 1'b0;
      level_q   <= 1'b0;
      elapsed_q <= '0;
      toggle_q  <= '0;
      mcand_q   <= '0;
      prod_q    <= '0;
      rem_q     <= '0;
      quo_q     <= '0;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      // output word leaves, unless the push step loads the next one
      if (m_valid_q && m_axis_tready && (state_q != S_PUSH)) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            func_q    <= func_e'(s_axis_tuser);
            pattern_q <= s_axis_tdata[0];
            state_q   <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_q <= S_PUSH;
          case (func_q)
            FUNC_START: begin
              running_q <= 1'b1;
              alarm_q   <= pattern_q;
              level_q   <= 1'b1;
              elapsed_q <= '0;
              toggle_q  <= (TB+1)'(pattern_q ? al_on_q : cd_on_q);
            end
            FUNC_STOP: begin
              running_q <= 1'b0;
              alarm_q   <= 1'b0;
              level_q   <= 1'b0;
            end
            FUNC_TICK: begin
              if (running_q) begin
                elapsed_q <= elapsed_inc;
                if (ge_max) begin
                  running_q <= 1'b0;
                  alarm_q   <= 1'b0;
                  level_q   <= 1'b0;
                end else if (ge_tog) begin
                  level_q <= !level_q;
                  if (!level_q) begin
                    toggle_q <= {1'b0, elapsed_inc} + (TB+1)'(sel_on);
                  end else if (ge_win) begin
                    toggle_q <= {1'b0, elapsed_inc} + (TB+1)'(sel_end);
                  end else begin
                    mcand_q <= elapsed_inc;
                    prod_q  <= PW'(gap_diff);
                    cnt_q   <= '0;
                    state_q <= S_MUL;
                  end
                end
              end
            end
            default: ;
          endcase
        end
        S_MUL: begin
          prod_q <= prod_nx;
          cnt_q  <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            rem_q   <= RW'(prod_nx[PW-1:GAP_W]);
            quo_q   <= prod_nx[GAP_W-1:0];
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q <= div_r;
          quo_q <= {quo_q[GAP_W-2:0], div_ge};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNT_LAST) begin
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          toggle_q <= {1'b0, elapsed_q} + (TB+1)'(gap_val);
          state_q  <= S_PUSH;
        end
        S_PUSH: begin
          if (push_ok) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {running_q, level_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // the buzzer never sounds without a running pattern
  a_level_needs_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> !level_q)
    else $error("buzzer level set while idle");

  // the gap datapath only runs for a running pattern that just went quiet
  a_ramp_context: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL || state_q == S_DIV) |-> (running_q && !level_q))
    else $error("ramp arithmetic outside an off gap");

  // restoring divide keeps the partial remainder below the window
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (rem_q < RW'(sel_win)))
    else $error("divider remainder out of range");

  // a new result word is only loaded from the push step
  a_load_from_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == S_PUSH))
    else $error("result word loaded outside push step");
`endif

endmodule

>>> dv/ramped_beep_pattern_timer_test.sv
module ramped_beep_pattern_timer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rbpt_pkg::*;

  localparam int unsigned TIME_BITS = 24;
  localparam logic [TIME_BITS-1:0] ELAPSED_MAX = '1;

  typedef struct packed {
    logic active;
    logic buzzer_on;
  } beep_word_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [7:0]        s_axis_tdata;   // [0] pattern, [7:1] zero
  logic [1:0]        s_axis_tuser;   // [1:0] func
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;   // [0] buzzer_on, [1] active
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [CFG_W-1:0]  pwdata;
  logic [CFG_W-1:0]  prdata;
  logic              pready;

  ramped_beep_pattern_timer #(
    .TIME_BITS(TIME_BITS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  // timer state as the block should hold it
  logic [31:0]          timing_reg [8];
  logic                 beep_running;
  logic                 beep_alarm;
  logic                 beep_level;
  logic [TIME_BITS-1:0] elapsed_ms;
  logic [TIME_BITS:0]   toggle_at_ms;
  beep_word_t           beep_expect_q[$];

  int err_count;
  int burst_left;
  int ready_left;

  // 8 ns clock
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // run limit
  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [31:0] reg_mask(logic [2:0] idx);
    return (idx == REG_MAX_DUR || idx == REG_CD_WINDOW) ? 32'h00FF_FFFF : 32'h0000_FFFF;
  endfunction

  // off gap on a linear ramp, rounded down
  function automatic logic [63:0] off_gap(logic [63:0] g_start, logic [63:0] g_stop,
                                          logic [63:0] window);
    logic [63:0] num;
    logic [63:0] q;
    if (64'(elapsed_ms) >= window) return g_stop;
    if (g_start >= g_stop) begin
      num = 64'(elapsed_ms) * (g_start - g_stop);
      q = num / window;
      if (q * window != num) q++;
      return g_start - q;
    end
    return g_start + (64'(elapsed_ms) * (g_stop - g_start)) / window;
  endfunction

  function automatic void halt_pattern();
    beep_running = 1'b0;
    beep_alarm   = 1'b0;
    beep_level   = 1'b0;
  endfunction

  // advance the timer state by one word and give the resulting levels
  function automatic beep_word_t predict_beep(func_e f, logic pat);
    logic [63:0] add;
    case (f)
      FUNC_START: begin
        beep_running = 1'b1;
        beep_alarm   = pat;
        elapsed_ms   = '0;
        beep_level   = 1'b1;
        toggle_at_ms = (TIME_BITS+1)'(pat ? timing_reg[REG_AL_ON] : timing_reg[REG_CD_ON]);
      end
      FUNC_STOP: begin
        if (beep_running) halt_pattern();
      end
      FUNC_TICK: begin
        if (beep_running) begin
          if (elapsed_ms != ELAPSED_MAX) elapsed_ms++;
          if (64'(elapsed_ms) >= 64'(timing_reg[REG_MAX_DUR])) begin
            halt_pattern();
          end else if ({1'b0, elapsed_ms} >= toggle_at_ms) begin
            beep_level = !beep_level;
            if (beep_level)
              add = 64'(beep_alarm ? timing_reg[REG_AL_ON] : timing_reg[REG_CD_ON]);
            else if (beep_alarm)
              add = off_gap(64'(timing_reg[REG_AL_START]), 64'(timing_reg[REG_AL_END]),
                            64'(AL_WINDOW));
            else
              add = off_gap(64'(timing_reg[REG_CD_START]), 64'(timing_reg[REG_CD_END]),
                            64'(timing_reg[REG_CD_WINDOW]));
            toggle_at_ms = (TIME_BITS+1)'(64'(elapsed_ms) + add);
          end
        end
      end
      default: ;
    endcase
    return '{active: beep_running, buzzer_on: beep_level};
  endfunction

  // receiver stall pattern, mostly short runs with some long ready stretches
  always @(posedge clk_i) begin
    if (ready_left != 0) begin
      ready_left <= ready_left - 1;
    end else begin
      m_axis_tready <= ~m_axis_tready;
      if (m_axis_tready)
        ready_left <= $urandom_range(0, 4);
      else if ($urandom_range(0, 7) == 0)
        ready_left <= $urandom_range(40, 120);
      else
        ready_left <= $urandom_range(0, 12);
    end
  end

  // compare each output word with the oldest expectation
  always @(posedge clk_i) begin : check_word
    beep_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (beep_expect_q.size() == 0) begin
        $error("output word with no expectation: tdata %0h", m_axis_tdata);
        err_count++;
      end else begin
        want = beep_expect_q.pop_front();
        if (m_axis_tdata[0] !== want.buzzer_on) begin
          $error("buzzer_on expected %0b actual %0b", want.buzzer_on, m_axis_tdata[0]);
          err_count++;
        end
        if (m_axis_tdata[1] !== want.active) begin
          $error("active expected %0b actual %0b", want.active, m_axis_tdata[1]);
          err_count++;
        end
      end
    end
  end

  // register access, setup then access phase
  task automatic apb_write(logic [2:0] idx, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    timing_reg[idx] = value & reg_mask(idx);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(logic [2:0] idx);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== timing_reg[idx]) begin
      $error("prdata of register %0d expected %0h actual %0h", idx, timing_reg[idx], prdata);
      err_count++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_timing(logic [31:0] max_dur, logic [31:0] window, logic [31:0] cd_on,
                            logic [31:0] cd_start, logic [31:0] cd_stop, logic [31:0] al_on,
                            logic [31:0] al_start, logic [31:0] al_stop);
    apb_write(REG_MAX_DUR, max_dur);
    apb_write(REG_CD_WINDOW, window);
    apb_write(REG_CD_ON, cd_on);
    apb_write(REG_CD_START, cd_start);
    apb_write(REG_CD_END, cd_stop);
    apb_write(REG_AL_ON, al_on);
    apb_write(REG_AL_START, al_start);
    apb_write(REG_AL_END, al_stop);
  endtask

  // send one input word, in bursts with random gaps between them
  task automatic send_word(func_e f, logic pat);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= f;
    s_axis_tdata  <= {7'd0, pat};
    do @(posedge clk_i); while (!s_axis_tready);
    beep_expect_q.push_back(predict_beep(f, pat));
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 100) : $urandom_range(0, 10);
    end
  endtask

  // hold the sender until every expected word is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (beep_expect_q.size() != 0) @(posedge clk_i);
    @(posedge clk_i);
  endtask

  // random timing value, mostly small so toggles and stops come quickly
  function automatic logic [31:0] pick_timing(int unsigned hi);
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return $urandom();
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  // every register: reset value, all ones, zero and random with bits above its width
  task automatic test_register_access();
    for (int i = 0; i < 8; i++) begin
      apb_read_check(3'(i));
      apb_write(3'(i), 32'hFFFF_FFFF);
      apb_read_check(3'(i));
      apb_write(3'(i), 32'd0);
      apb_read_check(3'(i));
      apb_write(3'(i), $urandom());
      apb_read_check(3'(i));
    end
  endtask

  task automatic test_directed_cases();
    // short pattern timing so toggles show up within a few ticks
    set_timing(20, 4, 2, 5, 1, 1, 3, 9);
    send_word(FUNC_NONE, 1'b1);
    send_word(FUNC_TICK, 1'b1);
    send_word(FUNC_STOP, 1'b1);
    send_word(FUNC_START, 1'b0);
    repeat (5) send_word(FUNC_TICK, 1'($urandom_range(0, 1)));
    send_word(FUNC_NONE, 1'b0);
    // restart while running, as alarm
    send_word(FUNC_START, 1'b1);
    repeat (3) send_word(FUNC_TICK, 1'b0);
    send_word(FUNC_STOP, 1'b1);
    drain_results();

    // zero maximum stops at the first tick
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    send_word(FUNC_START, 1'b0);
    send_word(FUNC_TICK, 1'b0);
    drain_results();

    // zero on time and zero window
    set_timing(12, 0, 0, 7, 3, 0, 0, 0);
    send_word(FUNC_START, 1'b0);
    repeat (4) send_word(FUNC_TICK, 1'b0);
    drain_results();

    // widest values in the ramp arithmetic
    set_timing(32'h00FF_FFFF, 32'h00FF_FFFF, 1, 32'h0000_FFFF, 0, 1, 0, 32'h0000_FFFF);
    send_word(FUNC_START, 1'b0);
    repeat (2) send_word(FUNC_TICK, 1'b0);
    send_word(FUNC_START, 1'b1);
    send_word(FUNC_TICK, 1'b0);
    drain_results();
  endtask

  // mostly start followed by runs of ticks, with stops and unused codes mixed in
  task automatic test_random_traffic();
    func_e f;
    int    counted;
    int    pick;
    logic  was_running;
    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      set_timing(pick_timing(160), pick_timing(80), pick_timing(6), pick_timing(40),
                 pick_timing(40), pick_timing(6), pick_timing(40), pick_timing(40));
      counted = 0;
      while (counted < 200) begin
        pick = $urandom_range(0, 99);
        if (!beep_running && $urandom_range(0, 4) != 0) f = FUNC_START;
        else if (pick < 88) f = FUNC_TICK;
        else if (pick < 93) f = FUNC_NONE;
        else if (pick < 97) f = FUNC_STOP;
        else f = FUNC_START;
        was_running = beep_running;
        send_word(f, 1'($urandom_range(0, 1)));
        if (was_running || f == FUNC_START) counted++;
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = FUNC_TICK;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    err_count     = 0;
    burst_left    = 0;
    ready_left    = 0;
    timing_reg[REG_MAX_DUR]   = 32'(RST_MAX_DUR);
    timing_reg[REG_CD_WINDOW] = 32'(RST_CD_WINDOW);
    timing_reg[REG_CD_ON]     = 32'(RST_CD_ON);
    timing_reg[REG_CD_START]  = 32'(RST_CD_START);
    timing_reg[REG_CD_END]    = 32'(RST_CD_END);
    timing_reg[REG_AL_ON]     = 32'(RST_AL_ON);
    timing_reg[REG_AL_START]  = 32'(RST_AL_START);
    timing_reg[REG_AL_END]    = 32'(RST_AL_END);
    beep_running = 1'b0;
    beep_alarm   = 1'b0;
    beep_level   = 1'b0;
    elapsed_ms   = '0;
    toggle_at_ms = '0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_register_access();
    test_directed_cases();
    test_random_traffic();

    drain_results();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
